>>> src/sld_pkg.sv
// shared types and constants for the s-record line decoder
// no dependencies; used by every module of the decoder
`default_nettype none

package sld_pkg;

	// line status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_TERM  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// result kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// characters and checksum target
	localparam logic [7:0] CHAR_S   = 8'h53;
	localparam logic [7:0] SUM_GOOD = 8'hff;

	// queue between the classifier and the decoder
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// one classified character
	typedef struct packed {
		logic       line_end;
		logic       is_s;
		logic       is_hex;
		logic [3:0] nib;
	} tok_t;

	// hex digit decode, either case
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/sld_front.sv
// input stage: accepts characters and classifies them into tokens
// depends on sld_pkg
`default_nettype none

module sld_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         in_last,
	input  wire logic [7:0]   in_ch,
	output logic              tok_valid,
	input  wire logic         tok_ready,
	output sld_pkg::tok_t     tok
);

	logic          valid_s1;
	sld_pkg::tok_t tok_s1;
	logic [4:0]    hex;

	assign hex = sld_pkg::hex_decode(in_ch);
	assign in_ready = !valid_s1 || tok_ready;
	assign tok_valid = valid_s1;
	assign tok = tok_s1;

	// classify and hold one token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tok_s1 <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				tok_s1.line_end <= in_last;
				tok_s1.is_s <= (in_ch == sld_pkg::CHAR_S);
				tok_s1.is_hex <= hex[4];
				tok_s1.nib <= hex[3:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> src/sld_queue.sv
// short token queue decoupling classifier from decoder
// depends on sld_pkg
`default_nettype none

module sld_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire sld_pkg::tok_t push_tok,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output sld_pkg::tok_t      pop_tok
);

	sld_pkg::tok_t                   entry_q [sld_pkg::QUEUE_DEPTH];
	logic [sld_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [sld_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [sld_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != sld_pkg::QUEUE_CNT_W'(sld_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_tok = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// token storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

`default_nettype wire

>>> src/sld_back.sv
// record decoder: walks the token stream and drives the result register
// depends on sld_pkg
`default_nettype none

module sld_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   load_offset,
	input  wire logic          tok_valid,
	output logic               tok_ready,
	input  wire sld_pkg::tok_t tok,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               out_kind,
	output logic [31:0]        out_addr,
	output logic [7:0]         out_data,
	output logic [1:0]         out_status
);

	typedef enum logic [2:0] {
		PH_LEAD, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM, PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [3:0]  high_nib_q;
	logic        nib_pend_q;
	logic [2:0]  addr_bytes_q;
	logic [31:0] addr_acc_q;
	logic [31:0] base_q;
	logic [7:0]  sum_q;
	logic [7:0]  idx_q;
	logic [7:0]  data_total_q;
	logic [1:0]  line_res_q;
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_addr_q;
	logic [7:0]  out_data_q;
	logic [1:0]  out_status_q;

	logic        take;
	logic        emit;
	logic [7:0]  byte_val;
	logic [7:0]  sum_next;
	logic [8:0]  idx_inc;
	logic [31:0] acc_next;

	assign tok_ready = !out_valid_q || out_ready;
	assign take = tok_valid && tok_ready;
	assign byte_val = {high_nib_q, tok.nib};
	assign sum_next = sum_q + byte_val;
	assign idx_inc = {1'b0, idx_q} + 9'd1;
	assign acc_next = {addr_acc_q[23:0], byte_val};

	// a result is loaded at a line end and for each completed data byte
	assign emit = take && (tok.line_end || (phase_q == PH_DATA && tok.is_hex && nib_pend_q));

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_addr = out_addr_q;
	assign out_data = out_data_q;
	assign out_status = out_status_q;

	// line state machine and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			high_nib_q <= '0;
			nib_pend_q <= 1'b0;
			addr_bytes_q <= '0;
			addr_acc_q <= '0;
			base_q <= '0;
			sum_q <= '0;
			idx_q <= '0;
			data_total_q <= '0;
			line_res_q <= sld_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_kind_q <= sld_pkg::KIND_WRITE;
			out_addr_q <= '0;
			out_data_q <= '0;
			out_status_q <= sld_pkg::ST_OK;
		end else begin
			// result register fills on a new result, empties when taken downstream
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (tok.line_end) begin
					// line status, then start over
					out_kind_q <= sld_pkg::KIND_STATUS;
					out_addr_q <= '0;
					out_data_q <= '0;
					out_status_q <= (phase_q == PH_DONE) ? line_res_q : sld_pkg::ST_ERROR;
					phase_q <= PH_LEAD;
					high_nib_q <= '0;
					nib_pend_q <= 1'b0;
					addr_bytes_q <= '0;
					addr_acc_q <= '0;
					sum_q <= '0;
					idx_q <= '0;
					data_total_q <= '0;
					line_res_q <= sld_pkg::ST_OK;
				end else if (phase_q == PH_DONE) begin
					// trailing characters ignored
				end else if (phase_q == PH_LEAD) begin
					if (tok.is_s) begin
						phase_q <= PH_TYPE;
					end else begin
						line_res_q <= sld_pkg::ST_ERROR;
						phase_q <= PH_DONE;
					end
				end else if (!tok.is_hex) begin
					line_res_q <= sld_pkg::ST_ERROR;
					phase_q <= PH_DONE;
				end else if (phase_q == PH_TYPE) begin
					case (tok.nib)
						4'd1: begin
							addr_bytes_q <= 3'd2;
							phase_q <= PH_COUNT;
						end
						4'd2: begin
							addr_bytes_q <= 3'd3;
							phase_q <= PH_COUNT;
						end
						4'd3: begin
							addr_bytes_q <= 3'd4;
							phase_q <= PH_COUNT;
						end
						4'd0, 4'd5: begin
							line_res_q <= sld_pkg::ST_OK;
							phase_q <= PH_DONE;
						end
						4'd7, 4'd8, 4'd9: begin
							line_res_q <= sld_pkg::ST_TERM;
							phase_q <= PH_DONE;
						end
						default: begin
							line_res_q <= sld_pkg::ST_ERROR;
							phase_q <= PH_DONE;
						end
					endcase
				end else if (!nib_pend_q) begin
					high_nib_q <= tok.nib;
					nib_pend_q <= 1'b1;
				end else begin
					// a full byte is in hand
					nib_pend_q <= 1'b0;
					sum_q <= sum_next;
					case (phase_q)
						PH_COUNT: begin
							data_total_q <= (byte_val > {5'b0, addr_bytes_q})
								? byte_val - {5'b0, addr_bytes_q} - 8'd1 : 8'd0;
							idx_q <= '0;
							phase_q <= PH_ADDR;
						end
						PH_ADDR: begin
							addr_acc_q <= acc_next;
							base_q <= acc_next + load_offset;
							if (idx_inc >= {6'b0, addr_bytes_q}) begin
								idx_q <= '0;
								phase_q <= (data_total_q != 8'd0) ? PH_DATA : PH_CSUM;
							end else begin
								idx_q <= idx_inc[7:0];
							end
						end
						PH_DATA: begin
							out_kind_q <= sld_pkg::KIND_WRITE;
							out_addr_q <= base_q + {24'b0, idx_q};
							out_data_q <= byte_val;
							out_status_q <= sld_pkg::ST_OK;
							idx_q <= idx_inc[7:0];
							if (idx_inc >= {1'b0, data_total_q}) begin
								phase_q <= PH_CSUM;
							end
						end
						default: begin
							line_res_q <= (sum_next == sld_pkg::SUM_GOOD)
								? sld_pkg::ST_OK : sld_pkg::ST_ERROR;
							phase_q <= PH_DONE;
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/srecord_line_decoder.sv
// path: a character is registered in the classifier, then held in the token queue, then reaches the result register
// throughput: one character per cycle while the queue has room; the decoder takes one token a cycle unless
// the result register is full and not being taken
// reset: arst_n clears the load offset, the token queue and the line state;
// the decoder then waits for the leading S of a new line
// depends on sld_pkg, sld_front, sld_queue and sld_back
`default_nettype none

module srecord_line_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load_offset_wr_en,
	input  wire logic [31:0] load_offset,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // ch
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // write_address, write_data, line_status, zero pad
	output logic             m_tuser   // result_kind
);

	logic          [31:0] load_offset_q;
	logic                 f_valid;
	logic                 f_ready;
	sld_pkg::tok_t        f_tok;
	logic                 q_valid;
	logic                 q_ready;
	sld_pkg::tok_t        q_tok;
	logic          [31:0] res_addr;
	logic          [7:0]  res_data;
	logic          [1:0]  res_status;

	// load offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_offset_q <= '0;
		end else if (load_offset_wr_en) begin
			load_offset_q <= load_offset;
		end
	end

	sld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_last   (s_tlast),
		.in_ch     (s_tdata),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	sld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_tok    (q_tok)
	);

	sld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_offset (load_offset_q),
		.tok_valid   (q_valid),
		.tok_ready   (q_ready),
		.tok         (q_tok),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_addr    (res_addr),
		.out_data    (res_data),
		.out_status  (res_status)
	);

	// pack result fields, lowest first
	assign m_tdata = {6'b0, res_status, res_data, res_addr};

endmodule

`default_nettype wire

>>> verif/tb_srecord_line_decoder.sv
// self-checking testbench for srecord_line_decoder: s-record lines in, byte writes and line status out
// depends on sld_pkg and the srecord_line_decoder rtl; nothing else is read
module tb_srecord_line_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// one character transaction towards the decoder
	typedef struct packed {
		logic       last;
		logic [7:0] ch;
	} line_char_t;

	// one decoded result as it should leave the decoder
	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [1:0]  status;
	} dec_result_t;

	// where the line parser stands
	typedef enum logic [2:0] {
		P_LEAD, P_TYPE, P_COUNT, P_ADDR, P_DATA, P_CSUM, P_DONE
	} line_phase_t;

	// how a generated record is damaged
	typedef enum int {
		FLAW_NONE, FLAW_BAD_DIGIT, FLAW_CUT, FLAW_TRAIL, FLAW_BAD_LEAD
	} flaw_t;

	// how the byte count of a generated record is chosen
	typedef enum int {
		COUNT_EXACT, COUNT_SHORT, COUNT_ANY
	} count_mode_t;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        load_offset_wr_en = 1'b0;
	logic [31:0] load_offset = 32'h0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // ch
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;  // write_address, write_data, line_status, zero pad
	logic        m_tuser;  // result_kind

	srecord_line_decoder u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.load_offset_wr_en (load_offset_wr_en),
		.load_offset       (load_offset),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	line_char_t  char_queue[$];
	dec_result_t due_results[$];
	int          chars_planned = 0;
	int          chars_taken = 0;
	int          fault_count = 0;
	logic        in_fire = 1'b0;

	// decoder state as predicted
	line_phase_t ph = P_LEAD;
	logic [3:0]  hi_nib = 4'h0;
	logic        nib_held = 1'b0;
	logic [7:0]  byte_cnt = 8'h00;
	logic [2:0]  addr_len = 3'd0;
	logic [31:0] addr_acc = 32'h0;
	logic [7:0]  sum_acc = 8'h00;
	logic [7:0]  idx = 8'h00;
	logic [1:0]  line_st = sld_pkg::ST_OK;
	logic [31:0] offset_copy = 32'h0;

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] payload_len();
		return (byte_cnt > 8'(addr_len)) ? byte_cnt - 8'(addr_len) - 8'd1 : 8'd0;
	endfunction

	function automatic void close_line(input logic [1:0] st);
		line_st = st;
		ph = P_DONE;
	endfunction

	// advance the predicted decoder by one character, queue any result it gives
	function automatic void decode_char(input logic eol, input logic [7:0] c);
		int          nib;
		logic [7:0]  b;
		dec_result_t r;
		if (eol) begin
			r.kind = sld_pkg::KIND_STATUS;
			r.addr = 32'h0;
			r.data = 8'h00;
			r.status = (ph == P_DONE) ? line_st : sld_pkg::ST_ERROR;
			due_results.push_back(r);
			ph = P_LEAD;
			hi_nib = 4'h0;
			nib_held = 1'b0;
			byte_cnt = 8'h00;
			addr_len = 3'd0;
			addr_acc = 32'h0;
			sum_acc = 8'h00;
			idx = 8'h00;
			line_st = sld_pkg::ST_OK;
			return;
		end
		if (ph == P_DONE) return;
		if (ph == P_LEAD) begin
			if (c == sld_pkg::CHAR_S) ph = P_TYPE;
			else close_line(sld_pkg::ST_ERROR);
			return;
		end
		nib = nibble_of(c);
		if (nib < 0) begin
			close_line(sld_pkg::ST_ERROR);
			return;
		end
		if (ph == P_TYPE) begin
			case (nib)
				1: begin addr_len = 3'd2; ph = P_COUNT; end
				2: begin addr_len = 3'd3; ph = P_COUNT; end
				3: begin addr_len = 3'd4; ph = P_COUNT; end
				0, 5: close_line(sld_pkg::ST_OK);
				7, 8, 9: close_line(sld_pkg::ST_TERM);
				default: close_line(sld_pkg::ST_ERROR);
			endcase
			return;
		end
		// two digits make a byte
		if (!nib_held) begin
			hi_nib = nib[3:0];
			nib_held = 1'b1;
			return;
		end
		nib_held = 1'b0;
		b = {hi_nib, nib[3:0]};
		sum_acc = sum_acc + b;
		case (ph)
			P_COUNT: begin
				byte_cnt = b;
				idx = 8'h00;
				ph = P_ADDR;
			end
			P_ADDR: begin
				addr_acc = {addr_acc[23:0], b};
				idx = idx + 8'd1;
				if (idx >= 8'(addr_len)) begin
					idx = 8'h00;
					ph = (payload_len() != 8'h00) ? P_DATA : P_CSUM;
				end
			end
			P_DATA: begin
				r.kind = sld_pkg::KIND_WRITE;
				r.addr = addr_acc + offset_copy + 32'(idx);
				r.data = b;
				r.status = sld_pkg::ST_OK;
				due_results.push_back(r);
				idx = idx + 8'd1;
				if (idx >= payload_len()) ph = P_CSUM;
			end
			default: close_line((sum_acc == sld_pkg::SUM_GOOD) ? sld_pkg::ST_OK
				: sld_pkg::ST_ERROR);
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fault_count++;
		end
	endfunction

	// monitor: input transactions feed the prediction, output transactions are checked
	always @(posedge clk) begin
		dec_result_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				decode_char(s_tlast, s_tdata);
				chars_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual kind %0d tdata %h",
						$time, m_tuser, m_tdata);
					fault_count++;
				end else begin
					want = due_results.pop_front();
					compare_field("result_kind", 32'(want.kind), 32'(m_tuser));
					compare_field("write_address", want.addr, m_tdata[31:0]);
					compare_field("write_data", 32'(want.data), 32'(m_tdata[39:32]));
					compare_field("line_status", 32'(want.status), 32'(m_tdata[41:40]));
				end
			end
		end
	end

	// sender: bursts of characters with gaps between them
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		line_char_t nxt;
		logic       offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			offer = 1'b0;
			nxt = '0;
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end
			if (burst_left > 0) begin
				if (char_queue.size() > 0) begin
					nxt = char_queue.pop_front();
					offer = 1'b1;
					burst_left--;
				end
			end else begin
				gap_left--;
			end
			s_tvalid <= offer;
			if (offer) begin
				s_tdata <= nxt.ch;
				s_tlast <= nxt.last;
			end
		end
	end

	// receiver: stall pattern of its own, with long hold-offs now and then
	int hold_left = 0;
	int next_hold = 300;
	int rx_cycle = 0;
	int rx_mode = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (chars_taken >= next_hold) begin
			hold_left = HOLD_CYCLES;
			next_hold += 450;
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 32 == 0) rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= (rx_cycle % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// watchdog on cycles with no transaction on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic void push_char(input logic last, input logic [7:0] c);
		line_char_t it;
		it.last = last;
		it.ch = c;
		char_queue.push_back(it);
		chars_planned++;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
		return c;
	endfunction

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// build one record line, possibly damaged, and queue its characters
	function automatic void add_record(input int rtype, input int ndata, input logic [31:0] addr,
			input count_mode_t cmode, input bit bad_sum, input flaw_t flaw, input bit rail_data);
		logic [7:0] bytes[$];
		logic [7:0] chars[$];
		logic [7:0] sum;
		logic [7:0] c;
		int         alen;
		int         cut;
		alen = (rtype == 2 || rtype == 8) ? 3 : (rtype == 3 || rtype == 7) ? 4 : 2;
		case (cmode)
			COUNT_EXACT: bytes.push_back(8'(alen + ndata + 1));
			COUNT_SHORT: begin
				ndata = 0;
				bytes.push_back(8'($urandom_range(0, alen)));
			end
			default: bytes.push_back(8'($urandom_range(0, 255)));
		endcase
		for (int i = alen - 1; i >= 0; i--) bytes.push_back(addr[8*i +: 8]);
		for (int i = 0; i < ndata; i++) begin
			if (rail_data) bytes.push_back((i % 2 == 1) ? 8'hff : 8'h00);
			else bytes.push_back(8'($urandom_range(0, 255)));
		end
		sum = 8'h00;
		foreach (bytes[i]) sum = sum + bytes[i];
		bytes.push_back(~sum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00));
		chars.push_back(sld_pkg::CHAR_S);
		chars.push_back(hex_char(4'(rtype)));
		foreach (bytes[i]) begin
			chars.push_back(hex_char(bytes[i][7:4]));
			chars.push_back(hex_char(bytes[i][3:0]));
		end
		case (flaw)
			FLAW_BAD_DIGIT: chars[$urandom_range(1, chars.size() - 1)] = non_hex_char();
			FLAW_CUT: begin
				cut = $urandom_range(0, chars.size() - 1);
				while (chars.size() > cut) void'(chars.pop_back());
			end
			FLAW_TRAIL: repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
			FLAW_BAD_LEAD: begin
				do c = 8'($urandom_range(0, 255)); while (c == sld_pkg::CHAR_S);
				chars[0] = c;
			end
			default: ;
		endcase
		foreach (chars[i]) push_char(1'b0, chars[i]);
		push_char(1'b1, 8'($urandom_range(0, 255)));
	endfunction

	// random line mix, mostly well formed records
	function automatic void add_random_lines(input int quota);
		int start;
		int roll;
		int nd;
		int skip_types[5] = '{0, 5, 7, 8, 9};
		start = chars_planned;
		while (chars_planned - start < quota) begin
			roll = $urandom_range(0, 99);
			nd = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
			if (roll < 60) begin
				add_record($urandom_range(1, 3), nd, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
			end else if (roll < 68) begin
				add_record(skip_types[$urandom_range(0, 4)], nd, pick_address(), COUNT_EXACT, 0,
					FLAW_NONE, 0);
			end else if (roll < 73) begin
				add_record(($urandom_range(0, 1) == 1) ? 4 + 2 * $urandom_range(0, 1) :
					$urandom_range(10, 15), nd, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
			end else if (roll < 78) begin
				add_record($urandom_range(1, 3), 0, pick_address(), COUNT_SHORT, 0, FLAW_NONE, 0);
			end else if (roll < 82) begin
				add_record($urandom_range(1, 3), $urandom_range(0, 8), pick_address(), COUNT_ANY,
					0, FLAW_NONE, 0);
			end else if (roll < 86) begin
				add_record($urandom_range(1, 3), nd, pick_address(), COUNT_EXACT, 1, FLAW_NONE, 0);
			end else if (roll < 89) begin
				add_record($urandom_range(0, 9), nd, pick_address(), COUNT_EXACT, 0,
					FLAW_BAD_DIGIT, 0);
			end else if (roll < 92) begin
				add_record($urandom_range(1, 3), nd, pick_address(), COUNT_EXACT, 0, FLAW_CUT, 0);
			end else if (roll < 95) begin
				add_record($urandom_range(0, 9), nd, pick_address(), COUNT_EXACT, 0, FLAW_TRAIL, 0);
			end else if (roll < 97) begin
				add_record($urandom_range(1, 3), nd, pick_address(), COUNT_EXACT, 0,
					FLAW_BAD_LEAD, 0);
			end else begin
				// noise line: a leading S now and then, then anything
				if ($urandom_range(0, 1) == 1) push_char(1'b0, sld_pkg::CHAR_S);
				repeat ($urandom_range(0, 12)) begin
					if ($urandom_range(0, 1) == 1) push_char(1'b0, hex_char(4'($urandom_range(0, 15))));
					else push_char(1'b0, 8'($urandom_range(0, 255)));
				end
				push_char(1'b1, 8'($urandom_range(0, 255)));
			end
		end
	endfunction

	// wait until every character is taken and every result has come out
	task automatic wait_drained();
		while (char_queue.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write while the decoder is idle
	task automatic set_offset(input logic [31:0] value);
		wait_drained();
		@(negedge clk);
		load_offset_wr_en <= 1'b1;
		load_offset <= value;
		offset_copy = value;
		@(negedge clk);
		load_offset_wr_en <= 1'b0;
	endtask

	// main sequence
	initial begin
		int skip_list[5] = '{0, 5, 7, 8, 9};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		set_offset(32'h0000_0000);
		// extreme data bytes, address wrap at 32 bits, every record type the decoder accepts
		add_record(1, 2, 32'h0000_0000, COUNT_EXACT, 0, FLAW_NONE, 1);
		add_record(3, 3, 32'hffff_ffff, COUNT_EXACT, 0, FLAW_NONE, 1);
		add_record(2, 4, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		add_record(1, 0, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		foreach (skip_list[i])
			add_record(skip_list[i], 2, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		// bad type digits
		add_record(4, 1, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		add_record(6, 1, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		add_record(10, 1, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		add_record(15, 1, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		// bad leading character, also the character extremes
		push_char(1'b0, 8'hff);
		push_char(1'b0, 8'h00);
		push_char(1'b1, 8'hff);
		add_record(1, 3, pick_address(), COUNT_EXACT, 0, FLAW_BAD_LEAD, 0);
		// empty line and early line end
		push_char(1'b1, 8'h00);
		add_record(1, 3, pick_address(), COUNT_EXACT, 0, FLAW_CUT, 0);
		// bad character at a random place after the leading S
		add_record(2, 5, pick_address(), COUNT_EXACT, 0, FLAW_BAD_DIGIT, 0);
		// count too short for any data
		add_record(1, 0, pick_address(), COUNT_SHORT, 0, FLAW_NONE, 0);
		add_record(3, 0, pick_address(), COUNT_SHORT, 0, FLAW_NONE, 0);
		// wrong checksum and characters after the checksum
		add_record(1, 4, pick_address(), COUNT_EXACT, 1, FLAW_NONE, 0);
		add_record(3, 2, pick_address(), COUNT_EXACT, 0, FLAW_TRAIL, 0);
		add_random_lines(10);

		set_offset(32'hffff_ffff);
		add_record(1, 3, 32'h0000_0001, COUNT_EXACT, 0, FLAW_NONE, 0);
		// longest record: count ff
		add_record(1, 252, pick_address(), COUNT_EXACT, 0, FLAW_NONE, 0);
		add_random_lines(10);

		set_offset($urandom());
		add_random_lines(10);

		set_offset(32'h8000_0000);
		add_random_lines(10);

		set_offset(32'h0000_0001);
		add_random_lines(10);

		wait_drained();
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
src/sld_pkg.sv
src/sld_front.sv
src/sld_queue.sv
src/sld_back.sv
src/srecord_line_decoder.sv
verif/tb_srecord_line_decoder.sv
